// ===== hdl/motor_command_frame_builder_defines.svh =====
// Assertion macros shared by the checker of the motor command frame builder.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef MOTOR_COMMAND_FRAME_BUILDER_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, held off during reset
`define MCFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define MCFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mcfb_pkg.sv =====
// Package for the motor command frame builder: constants, queue entry type,
// and the byte-wise CRC-8 update. No dependencies.
package mcfb_pkg;

    localparam int FRAME_LEN_DEF = 15;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 12;

    // Request types
    localparam logic [2:0] REQ_SPEED     = 3'd0;
    localparam logic [2:0] REQ_POSITION  = 3'd1;
    localparam logic [2:0] REQ_ENABLE    = 3'd2;
    localparam logic [2:0] REQ_DISABLE   = 3'd3;
    localparam logic [2:0] REQ_SPEED_MD  = 3'd4;
    localparam logic [2:0] REQ_POS_MD    = 3'd5;

    // Command codes and selectors
    localparam logic [7:0] CMD_SPEED     = 8'h20;
    localparam logic [7:0] CMD_POSITION  = 8'h22;
    localparam logic [7:0] CMD_OUTPUT    = 8'h00;
    localparam logic [7:0] CMD_MODE      = 8'h01;
    localparam logic [7:0] SEL_OFF       = 8'h00;
    localparam logic [7:0] SEL_ON        = 8'h01;
    localparam logic [7:0] SEL_SPEED     = 8'h01;
    localparam logic [7:0] SEL_POSITION  = 8'h02;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_CURRENT = 2'd1;

    localparam logic signed [31:0] TARGET_LIMIT  = 32'sd21000000;
    localparam logic signed [11:0] CURRENT_LIMIT = 12'sd1200;
    localparam logic [7:0]         CRC_POLY      = 8'h8C;
    localparam logic [7:0]         DEVICE_ID_RST = 8'h00;

    // One classified command waiting for the byte sequencer
    typedef struct packed {
        logic        motion;  // speed or position: current goes into bytes 6..9
        logic [7:0]  code;
        logic [31:0] word;    // scaled target, or the selector in the low byte
    } entry_t;

    // Fold one byte into a reflected CRC-8
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/mcfb_if.sv =====
// Handshake channels of the motor command frame builder: request, frame, config.
// Depends on mcfb_pkg for the config port widths.
interface mcfb_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic signed [31:0] target_value;
    modport source (output valid, req_type, target_value, input ready);
    modport sink   (input valid, req_type, target_value, output ready);
endinterface

interface mcfb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface mcfb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mcfb_pkg::CFG_IDX_W-1:0]     reg_index;
    logic [mcfb_pkg::CFG_DATA_W-1:0]    wr_data;
    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hdl/motor_command_frame_builder.sv =====
// Throughput: one frame byte per cycle while the frame channel is not stalled,
// set by the byte sequencer in the back end; a two-entry queue lets requests
// land while a frame is still going out. A request passes the front register,
// the queue and the output register. Unused request types give no frame.
// Reset clears all control state, device id to 0 and drive current to 1200.
// Config writes are taken in every cycle (ready always high).
module motor_command_frame_builder #(
    parameter int FRAME_LEN = mcfb_pkg::FRAME_LEN_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    mcfb_req_if.sink     req,
    mcfb_frame_if.source frame,
    mcfb_cfg_if.sink     cfg
);

    logic [7:0]          device_id_reg;
    logic signed [11:0]  drive_current_reg;
    logic                push_valid;
    logic                push_ready;
    mcfb_pkg::entry_t    push_entry;
    logic                q_valid;
    logic                q_pop;
    mcfb_pkg::entry_t    q_entry;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg     <= mcfb_pkg::DEVICE_ID_RST;
            drive_current_reg <= mcfb_pkg::CURRENT_LIMIT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                mcfb_pkg::CFG_DEVICE_ID:     device_id_reg     <= cfg.wr_data[7:0];
                mcfb_pkg::CFG_DRIVE_CURRENT: drive_current_reg <= cfg.wr_data;
                default: ;
            endcase
        end
    end

    mcfb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_ready     (req.ready),
        .req_type     (req.req_type),
        .target_value (req.target_value),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    mcfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry)
    );

    mcfb_back #(
        .FRAME_LEN (FRAME_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .device_id     (device_id_reg),
        .drive_current (drive_current_reg),
        .out_valid     (frame.valid),
        .out_ready     (frame.ready),
        .out_byte      (frame.frame_byte),
        .out_end       (frame.frame_end)
    );

endmodule

// ===== hdl/mcfb_front.sv =====
// Front end: accepts requests, drops unused types, saturates and scales the
// target, and holds one classified entry for the queue. Depends on mcfb_pkg.
module mcfb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           req_type,
    input  logic signed [31:0]   target_value,
    output logic                 push_valid,
    input  logic                 push_ready,
    output mcfb_pkg::entry_t     push_entry
);

    logic              valid_reg;
    logic              valid_next;
    mcfb_pkg::entry_t  entry_reg;
    mcfb_pkg::entry_t  entry_next;
    logic              type_ok;
    logic              accept;
    logic signed [31:0] tgt_sat;
    logic signed [31:0] tgt_x100;

    // Saturate the target, then scale by 100 with shifts and adds
    always_comb
    begin
        if (target_value > mcfb_pkg::TARGET_LIMIT)
            tgt_sat = mcfb_pkg::TARGET_LIMIT;
        else if (target_value < -mcfb_pkg::TARGET_LIMIT)
            tgt_sat = -mcfb_pkg::TARGET_LIMIT;
        else
            tgt_sat = target_value;
        tgt_x100 = (tgt_sat <<< 6) + (tgt_sat <<< 5) + (tgt_sat <<< 2);
    end

    // Classify the request
    always_comb
    begin
        type_ok    = 1'b1;
        entry_next = '0;
        unique case (req_type) inside
            mcfb_pkg::REQ_SPEED, mcfb_pkg::REQ_POSITION:
            begin
                entry_next.motion = 1'b1;
                entry_next.code   = (req_type == mcfb_pkg::REQ_SPEED) ?
                                    mcfb_pkg::CMD_SPEED : mcfb_pkg::CMD_POSITION;
                entry_next.word   = tgt_x100;
            end
            mcfb_pkg::REQ_ENABLE:
            begin
                entry_next.code = mcfb_pkg::CMD_OUTPUT;
                entry_next.word = {24'h0, mcfb_pkg::SEL_ON};
            end
            mcfb_pkg::REQ_DISABLE:
            begin
                entry_next.code = mcfb_pkg::CMD_OUTPUT;
                entry_next.word = {24'h0, mcfb_pkg::SEL_OFF};
            end
            mcfb_pkg::REQ_SPEED_MD:
            begin
                entry_next.code = mcfb_pkg::CMD_MODE;
                entry_next.word = {24'h0, mcfb_pkg::SEL_SPEED};
            end
            mcfb_pkg::REQ_POS_MD:
            begin
                entry_next.code = mcfb_pkg::CMD_MODE;
                entry_next.word = {24'h0, mcfb_pkg::SEL_POSITION};
            end
            default:
            begin
                type_ok = 1'b0;
            end
        endcase
    end

    assign in_ready   = !valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    // Hold the entry until the queue takes it; drop unused request types
    always_comb
    begin
        if (accept)
            valid_next = type_ok;
        else if (push_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            entry_reg <= entry_next;
    end

endmodule

// ===== hdl/mcfb_queue.sv =====
// Two-entry queue of classified commands between front end and sequencer.
// Depends on mcfb_pkg for the entry type and depth.
module mcfb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  mcfb_pkg::entry_t  push_entry,
    output logic              pop_valid,
    input  logic              pop,
    output mcfb_pkg::entry_t  pop_entry
);

    localparam int PTR_W = $clog2(mcfb_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mcfb_pkg::QUEUE_DEPTH + 1);

    mcfb_pkg::entry_t   mem_reg [mcfb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;

    assign push_ready = (count_reg != CNT_W'(mcfb_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mcfb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mcfb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (do_push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== hdl/mcfb_back.sv =====
// Back end: steps through the frame one byte per beat, folds every data byte
// into the CRC and drives the output register. Depends on mcfb_pkg.
module mcfb_back #(
    parameter int FRAME_LEN = mcfb_pkg::FRAME_LEN_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  mcfb_pkg::entry_t         q_entry,
    output logic                     q_pop,
    input  logic [7:0]               device_id,
    input  logic signed [11:0]       drive_current,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               out_byte,
    output logic                     out_end
);

    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(FRAME_LEN - 1);

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [7:0]          crc_reg, crc_next;
    logic                valid_reg, valid_next;
    logic [7:0]          byte_reg;
    logic                end_reg;
    logic                advance;
    logic                emit;
    logic                at_last;
    logic [7:0]          byte_sel;
    logic signed [11:0]  cur_sat;
    logic signed [31:0]  cur_word;
    logic [31:0]         cur_bytes;

    // Saturate and scale the drive current
    always_comb
    begin
        if (drive_current > mcfb_pkg::CURRENT_LIMIT)
            cur_sat = mcfb_pkg::CURRENT_LIMIT;
        else if (drive_current < -mcfb_pkg::CURRENT_LIMIT)
            cur_sat = -mcfb_pkg::CURRENT_LIMIT;
        else
            cur_sat = drive_current;
        cur_word  = (32'(cur_sat) <<< 6) + (32'(cur_sat) <<< 5) + (32'(cur_sat) <<< 2);
        cur_bytes = q_entry.motion ? cur_word : '0;
    end

    assign advance = !valid_reg || out_ready;
    assign emit    = q_valid && advance;
    assign at_last = (idx_reg == LAST);
    assign q_pop   = emit && at_last;

    // Select the byte at the current position
    always_comb
    begin
        byte_sel = '0;
        if (at_last)
            byte_sel = crc_reg;
        else
        begin
            case (idx_reg)
                IDX_W'(0): byte_sel = q_entry.code;
                IDX_W'(1): byte_sel = device_id;
                IDX_W'(2): byte_sel = q_entry.word[7:0];
                IDX_W'(3): byte_sel = q_entry.word[15:8];
                IDX_W'(4): byte_sel = q_entry.word[23:16];
                IDX_W'(5): byte_sel = q_entry.word[31:24];
                IDX_W'(6): byte_sel = cur_bytes[7:0];
                IDX_W'(7): byte_sel = cur_bytes[15:8];
                IDX_W'(8): byte_sel = cur_bytes[23:16];
                IDX_W'(9): byte_sel = cur_bytes[31:24];
                default:   byte_sel = '0;
            endcase
        end
    end

    // Advance position and CRC; restart both after the CRC byte
    always_comb
    begin
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        valid_next = valid_reg;
        if (advance)
            valid_next = q_valid;
        if (emit)
        begin
            if (at_last)
            begin
                idx_next = '0;
                crc_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                crc_next = mcfb_pkg::crc8_step(crc_reg, byte_sel);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            crc_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= byte_sel;
            end_reg  <= at_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_end   = end_reg;

endmodule

// ===== hdl/mcfb_checker.sv =====
// Port-level checker for the motor command frame builder, bound to the top.
// Depends on mcfb_pkg and motor_command_frame_builder_defines.svh.
`include "motor_command_frame_builder_defines.svh"

module mcfb_checker #(
    parameter int FRAME_LEN = mcfb_pkg::FRAME_LEN_DEF
) (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       frame_valid,
    input logic       frame_ready,
    input logic [7:0] frame_byte,
    input logic       frame_end
);

    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(FRAME_LEN - 1);

    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             first_ok;

    // Track the byte position of the next beat on the frame channel
    always_comb
    begin
        pos_next = pos_reg;
        if (frame_valid && frame_ready)
            pos_next = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    assign first_ok = (frame_byte == mcfb_pkg::CMD_SPEED)  ||
                      (frame_byte == mcfb_pkg::CMD_POSITION) ||
                      (frame_byte == mcfb_pkg::CMD_OUTPUT) ||
                      (frame_byte == mcfb_pkg::CMD_MODE);

    `MCFB_ASSERT_NEXT(a_frame_hold, frame_valid && !frame_ready, frame_valid && $stable(frame_byte) && $stable(frame_end), "stalled frame beat changed")
    `MCFB_ASSERT_NOW(a_end_place, frame_valid, frame_end == (pos_reg == LAST), "frame end flag at wrong byte")
    `MCFB_ASSERT_NOW(a_first_code, frame_valid && (pos_reg == '0), first_ok, "frame opens with unknown command code")
    `MCFB_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind motor_command_frame_builder mcfb_checker #(
    .FRAME_LEN (FRAME_LEN)
) u_mcfb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_byte  (frame.frame_byte),
    .frame_end   (frame.frame_end)
);
